@@ src/pts_pkg.sv @@
// ----------------------------------------------------------------------------
// pts_pkg
// Shared constants and types of the periodic timer scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int SLOTS      = 16;
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MAX_FIRED  = 16;
    localparam int FIRE_CNT_W = $clog2(MAX_FIRED + 1);
    localparam int TIME_W     = 32;

    localparam logic CMD_REGISTER = 1'b0;
    localparam logic CMD_TICK     = 1'b1;

    // table write port: register (period + stamp + activate) or restamp only
    typedef struct packed {
        logic              en;
        logic              set_period;
        logic [SLOT_W-1:0] idx;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] stamp;
    } tbl_wr_t;

    // scan word aligned with the table read data
    typedef struct packed {
        logic              valid;
        logic              tail;
        logic              fired;
        logic [SLOT_W-1:0] idx;
    } scan_q_t;

    // outcome of one scan round
    typedef struct packed {
        logic              done;
        logic              found;
        logic [SLOT_W-1:0] idx;
    } pick_res_t;

endpackage

@@ src/pts_table.sv @@
// ----------------------------------------------------------------------------
// pts_table
// Slot table: period and last-fire memories with registered read, plus
// active flags cleared at reset.
// ----------------------------------------------------------------------------
module pts_table
    import pts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  tbl_wr_t           wr,
    input  logic [SLOT_W-1:0] rd_idx,
    output logic [TIME_W-1:0] rd_period,
    output logic [TIME_W-1:0] rd_last,
    output logic              rd_active
);

    logic [TIME_W-1:0] period_mem [SLOTS];
    logic [TIME_W-1:0] last_mem   [SLOTS];
    logic [SLOTS-1:0]  active_reg;
    logic [TIME_W-1:0] rd_period_reg;
    logic [TIME_W-1:0] rd_last_reg;
    logic              rd_active_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en && wr.set_period)
        begin
            period_mem[wr.idx] <= wr.period;
        end
        rd_period_reg <= period_mem[rd_idx];
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            last_mem[wr.idx] <= wr.stamp;
        end
        rd_last_reg <= last_mem[rd_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= '0;
            rd_active_reg <= 1'b0;
        end
        else
        begin
            if (wr.en && wr.set_period)
            begin
                active_reg[wr.idx] <= 1'b1;
            end
            rd_active_reg <= active_reg[rd_idx];
        end
    end

    assign rd_period = rd_period_reg;
    assign rd_last   = rd_last_reg;
    assign rd_active = rd_active_reg;

endmodule

@@ src/pts_pick.sv @@
// ----------------------------------------------------------------------------
// pts_pick
// Due check and running maximum of overdue time over one scan round.
// ----------------------------------------------------------------------------
module pts_pick
    import pts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [TIME_W-1:0] now,
    input  scan_q_t           q,
    input  logic [TIME_W-1:0] period,
    input  logic [TIME_W-1:0] last_fire,
    input  logic              active,
    output pick_res_t         res
);

    logic [TIME_W-1:0] elapsed;
    logic              s_valid_reg;
    logic              s_tail_reg;
    logic              s_due_reg;
    logic [TIME_W-1:0] s_late_reg;
    logic [SLOT_W-1:0] s_idx_reg;
    logic              found_reg;
    logic              done_reg;
    logic [TIME_W-1:0] best_late_reg;
    logic [SLOT_W-1:0] best_idx_reg;
    logic              better;

    assign elapsed = now - last_fire;
    assign better  = s_valid_reg && s_due_reg && (!found_reg || s_late_reg > best_late_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
            s_tail_reg  <= 1'b0;
            s_due_reg   <= 1'b0;
            found_reg   <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            s_valid_reg <= q.valid;
            s_tail_reg  <= q.valid && q.tail;
            s_due_reg   <= active && !q.fired && (elapsed >= period);
            done_reg    <= s_valid_reg && s_tail_reg;
            if (start)
            begin
                found_reg <= 1'b0;
            end
            else if (better)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s_late_reg <= elapsed - period;
        s_idx_reg  <= q.idx;
        if (better)
        begin
            best_late_reg <= s_late_reg;
            best_idx_reg  <= s_idx_reg;
        end
    end

    assign res.done  = done_reg;
    assign res.found = found_reg;
    assign res.idx   = best_idx_reg;

endmodule

@@ src/periodic_timer_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// periodic_timer_scheduler_top
// Multi-channel periodic timer: register slots, fire due slots on ticks,
// most overdue first.
//
//   channel  signals                                 word
//   in       in_valid / in_ready                     command slot period_ms now_ms
//   out      out_valid / out_ready                   fired_slot last
//
// A register word is written to the table as it is accepted. A tick word runs one
// scan round per fired slot plus one closing round (a closing word instead once
// MAX_FIRED slots have fired), bound by the single table read port.
// Each round streams all slots through the due check and keeps the maximum.
// Reset clears the active flags; no clearing pass is needed.
// A stalled output holds the round that would emit the next word.
// ----------------------------------------------------------------------------
module periodic_timer_scheduler_top
    import pts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  command,
    input  logic [3:0]            slot,
    input  logic [TIME_W-1:0]     period_ms,
    input  logic [TIME_W-1:0]     now_ms,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [3:0]            fired_slot,
    output logic                  last
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_EMIT,
        ST_FINAL
    } state_t;

    state_t                state_reg;
    logic [SLOT_W-1:0]     scan_cnt_reg;
    logic [FIRE_CNT_W-1:0] fire_cnt_reg;
    logic [SLOTS-1:0]      fired_reg;
    logic [TIME_W-1:0]     now_reg;
    logic                  pend_reg;
    logic [SLOT_W-1:0]     pend_idx_reg;
    logic                  found_reg;
    logic [SLOT_W-1:0]     best_reg;
    logic                  out_valid_reg;
    logic [3:0]            fired_slot_reg;
    logic                  last_reg;
    scan_q_t               q_reg;

    tbl_wr_t               tbl_wr;
    pick_res_t             pick;
    logic [TIME_W-1:0]     rd_period;
    logic [TIME_W-1:0]     rd_last;
    logic                  rd_active;
    logic                  in_acc;
    logic                  out_free;
    logic                  emit_go;
    logic                  push;
    logic                  slot_ok;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign emit_go  = (state_reg == ST_EMIT) && (!pend_reg || out_free);
    assign push     = (emit_go && pend_reg) || ((state_reg == ST_FINAL) && out_free);
    assign slot_ok  = ({28'd0, slot} < 32'(SLOTS));

    always_comb
    begin
        tbl_wr            = '0;
        tbl_wr.period     = period_ms;
        tbl_wr.stamp      = now_ms;
        tbl_wr.idx        = SLOT_W'(slot);
        if (in_acc && command == CMD_REGISTER && slot_ok)
        begin
            tbl_wr.en         = 1'b1;
            tbl_wr.set_period = 1'b1;
        end
        else if (emit_go && found_reg)
        begin
            tbl_wr.en    = 1'b1;
            tbl_wr.idx   = best_reg;
            tbl_wr.stamp = now_reg;
        end
    end

    pts_table u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (tbl_wr),
        .rd_idx    (scan_cnt_reg),
        .rd_period (rd_period),
        .rd_last   (rd_last),
        .rd_active (rd_active)
    );

    pts_pick u_pick (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     ((state_reg == ST_SCAN) && (scan_cnt_reg == '0)),
        .now       (now_reg),
        .q         (q_reg),
        .period    (rd_period),
        .last_fire (rd_last),
        .active    (rd_active),
        .res       (pick)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_cnt_reg  <= '0;
            fire_cnt_reg  <= '0;
            fired_reg     <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            q_reg         <= '0;
        end
        else
        begin
            q_reg.valid <= (state_reg == ST_SCAN);
            q_reg.tail  <= (scan_cnt_reg == SLOT_W'(SLOTS - 1));
            q_reg.fired <= fired_reg[scan_cnt_reg];
            q_reg.idx   <= scan_cnt_reg;

            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc && command == CMD_TICK)
                    begin
                        fired_reg    <= '0;
                        fire_cnt_reg <= '0;
                        pend_reg     <= 1'b0;
                        scan_cnt_reg <= '0;
                        state_reg    <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (scan_cnt_reg == SLOT_W'(SLOTS - 1))
                    begin
                        scan_cnt_reg <= '0;
                        state_reg    <= ST_WAIT;
                    end
                    else
                    begin
                        scan_cnt_reg <= scan_cnt_reg + 1'b1;
                    end
                end
                ST_WAIT:
                begin
                    if (pick.done)
                    begin
                        found_reg <= pick.found;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (emit_go)
                    begin
                        if (found_reg)
                        begin
                            fired_reg[best_reg] <= 1'b1;
                            fire_cnt_reg        <= fire_cnt_reg + 1'b1;
                            pend_reg            <= 1'b1;
                            if (fire_cnt_reg == FIRE_CNT_W'(MAX_FIRED - 1))
                            begin
                                state_reg <= ST_FINAL;
                            end
                            else
                            begin
                                state_reg <= ST_SCAN;
                            end
                        end
                        else
                        begin
                            pend_reg  <= 1'b0;
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_FINAL:
                begin
                    if (out_free)
                    begin
                        pend_reg  <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && command == CMD_TICK)
        begin
            now_reg <= now_ms;
        end
        if ((state_reg == ST_WAIT) && pick.done)
        begin
            best_reg <= pick.idx;
        end
        if (emit_go && found_reg)
        begin
            pend_idx_reg <= best_reg;
        end
        if (push)
        begin
            fired_slot_reg <= 4'(pend_idx_reg);
            last_reg       <= (state_reg == ST_FINAL) || !found_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign fired_slot = fired_slot_reg;
    assign last       = last_reg;

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        pick.done |-> (state_reg == ST_WAIT))
        else $error("scan round finished outside wait state");

    a_no_refire: assert property (@(posedge clk) disable iff (!rst_n)
        (pick.done && pick.found) |-> !fired_reg[pick.idx])
        else $error("slot picked twice in one tick");

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> out_free)
        else $error("output word overwritten");

    a_no_input_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready)
        else $error("input accepted during tick");

    a_stamp_fired: assert property (@(posedge clk) disable iff (!rst_n)
        (tbl_wr.en && !tbl_wr.set_period) |=> fired_reg[$past(best_reg)])
        else $error("restamp of slot not marked fired");

endmodule

@@ bench/fire_order_checker.sv @@
// ----------------------------------------------------------------------------
// fire_order_checker
// Watches both channels of the periodic timer scheduler, keeps its own copy
// of the slot table, predicts the fired-slot words of every tick and compares
// each output word with the oldest prediction.
// ----------------------------------------------------------------------------
module fire_order_checker
    import pts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic              command,
    input  logic [3:0]        slot,
    input  logic [TIME_W-1:0] period_ms,
    input  logic [TIME_W-1:0] now_ms,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [3:0]        fired_slot,
    input  logic              last,
    output int                errors,
    output int                pending
);

    typedef struct packed {
        logic [3:0] slot;
        logic       last;
    } fire_word_t;

    logic              slot_armed    [SLOTS];
    logic [TIME_W-1:0] slot_interval [SLOTS];
    logic [TIME_W-1:0] fire_stamp    [SLOTS];
    fire_word_t        due_fires [$];
    fire_word_t        head;

    // most overdue first, ties to the lower slot, restamp what fires
    task automatic fire_due_slots(input logic [TIME_W-1:0] t);
        logic              due  [SLOTS];
        logic [TIME_W-1:0] late [SLOTS];
        int                order [MAX_FIRED];
        logic [TIME_W-1:0] span;
        int                n;
        int                best;
        bit                found;
        fire_word_t        w;
        for (int i = 0; i < SLOTS; i++)
        begin
            span    = t - fire_stamp[i];
            due[i]  = slot_armed[i] && (span >= slot_interval[i]);
            late[i] = span - slot_interval[i];
        end
        n = 0;
        while (n < MAX_FIRED)
        begin
            found = 0;
            best  = 0;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (due[i] && (!found || late[i] > late[best]))
                begin
                    best  = i;
                    found = 1;
                end
            end
            if (!found)
                break;
            due[best]        = 0;
            fire_stamp[best] = t;
            order[n]         = best;
            n++;
        end
        for (int k = 0; k < n; k++)
        begin
            w.slot = 4'(order[k]);
            w.last = (k == n - 1);
            due_fires.insert(due_fires.size(), w);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                slot_armed[i] = 0;
            due_fires.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (due_fires.size() == 0)
                begin
                    $error("fired_slot %0d last %0d with no firing pending", fired_slot, last);
                    errors++;
                end
                else
                begin
                    head = due_fires.pop_front();
                    if (fired_slot !== head.slot)
                    begin
                        $error("fired_slot: expected %0d, got %0d", head.slot, fired_slot);
                        errors++;
                    end
                    if (last !== head.last)
                    begin
                        $error("last: expected %0d, got %0d", head.last, last);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (command == CMD_REGISTER)
                begin
                    if (int'(slot) < SLOTS)
                    begin
                        slot_armed[slot]    = 1;
                        slot_interval[slot] = period_ms;
                        fire_stamp[slot]    = now_ms;
                    end
                end
                else
                    fire_due_slots(now_ms);
            end
            pending = due_fires.size();
        end
    end

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives register and tick words into the periodic timer scheduler: a
// directed pass over the corner cases, then random traffic with idle bursts
// on both sides, a long output stall and a drained pause. Checking is done by
// fire_order_checker.
// ----------------------------------------------------------------------------
module testbench;
    import pts_pkg::*;

    localparam int LIMIT = 500_000;

    logic              clk       = 0;
    logic              rst_n     = 0;
    logic              in_valid  = 0;
    logic              in_ready;
    logic              command   = CMD_REGISTER;
    logic [3:0]        slot      = '0;
    logic [TIME_W-1:0] period_ms = '0;
    logic [TIME_W-1:0] now_ms    = '0;
    logic              out_valid;
    logic              out_ready = 0;
    logic [3:0]        fired_slot;
    logic              last;

    int                errors;
    int                pending;
    int                cycle_count = 0;
    bit                quiet       = 0;
    bit                hold_req    = 0;
    logic [TIME_W-1:0] cur_time;

    periodic_timer_scheduler_top dut (.*);

    fire_order_checker watch (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    // output side: random stall bursts, one long hold on request
    initial
    begin
        bit held;
        held = 0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req && !held)
            begin
                out_ready <= 0;
                repeat (300) @(posedge clk);
                held = 1;
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1;
                @(posedge clk);
            end
        end
    end

    task automatic send_word(input logic c, input logic [3:0] s,
                             input logic [TIME_W-1:0] p, input logic [TIME_W-1:0] t);
        in_valid  <= 1;
        command   <= c;
        slot      <= s;
        period_ms <= p;
        now_ms    <= t;
        do
            @(posedge clk);
        while (!in_ready);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    task automatic drain;
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        bit                noise;
        bit                is_tick;
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] p;

        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed corners
        send_word(CMD_TICK,     4'd0,  32'hFFFF_FFFF, 32'd0);
        send_word(CMD_REGISTER, 4'd0,  32'd0,         32'hFFFF_FFF0);
        send_word(CMD_TICK,     4'd15, 32'd0,         32'hFFFF_FFF0);
        send_word(CMD_REGISTER, 4'd15, 32'hFFFF_FFFF, 32'd5);
        send_word(CMD_TICK,     4'd0,  32'd0,         32'd4);
        send_word(CMD_TICK,     4'd9,  32'd0,         32'hFFFF_FFFF);
        send_word(CMD_REGISTER, 4'd15, 32'd3,         32'd100);
        for (int i = 1; i < 15; i++)
            send_word(CMD_REGISTER, 4'(i), TIME_W'(i % 4), 32'd100);
        send_word(CMD_TICK, 4'd3, 32'd7, 32'd50);
        send_word(CMD_TICK, 4'd5, 32'd1, 32'd200);
        send_word(CMD_TICK, 4'd6, 32'd2, 32'd200);

        // sender pauses until every firing has come out
        drain();
        repeat ($urandom_range(5, 30)) @(posedge clk);

        cur_time = $urandom();
        for (int k = 0; k < 80; k++)
        begin
            quiet = (k >= 68);
            if (k == 30)
                hold_req = 1;
            noise   = ($urandom_range(0, 9) == 0);
            is_tick = (k >= 30 && k < 38) || ($urandom_range(0, 9) < 6);
            if (is_tick)
            begin
                cur_time = cur_time + ((k >= 30 && k < 38) ? 40 : $urandom_range(0, 25));
                t = noise ? TIME_W'($urandom()) : cur_time;
                send_word(CMD_TICK, 4'($urandom_range(0, 15)), TIME_W'($urandom()), t);
            end
            else
            begin
                p = ($urandom_range(0, 3) == 0) ? TIME_W'($urandom())
                                                : TIME_W'($urandom_range(0, 60));
                t = noise ? TIME_W'($urandom()) : cur_time;
                send_word(CMD_REGISTER, 4'($urandom_range(0, 15)), p, t);
            end
        end

        drain();
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
